FILE: rtl/bitstream_field_reader_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitstream field reader
// Checks compile in simulation and drop out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BITSTREAM_FIELD_READER_ASSERT_SVH
`define BITSTREAM_FIELD_READER_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define BFR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bitstream field reader check failed")
// Consequent must hold in the cycle after the antecedent.
`define BFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitstream field reader check failed")
`else
`define BFR_ASSERT_ALWAYS(lbl, prop)
`define BFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/bfr_pkg.sv
// ---------------------------------------------------------------------------
// Bitstream field reader package
// Request and result types, codes and fixed field widths.
// ---------------------------------------------------------------------------
package bfr_pkg;

    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 6;
    localparam int FIELD_W        = 32;
    localparam int POS_W          = 27;
    localparam int LEN_W          = 24;
    localparam int MAX_FIELD_BITS = 32;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_GET     = 2'd1,
        OP_ALIGN   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef struct packed {
        op_t                opcode;
        logic [BYTE_W-1:0]  byte_in;
        logic [CNT_W-1:0]   bit_count;
        logic               consume;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] field_bits;
        logic [LEN_W-1:0]   consumed_bytes;
        logic [LEN_W-1:0]   bytes_left;
    } rsp_t;

endpackage

FILE: rtl/bitstream_field_reader.sv
// ---------------------------------------------------------------------------
// Bitstream field reader: MSB-first field extractor for a byte stream
// Path: an accepted request goes into the request register, then into the result
// register, where it is taken; the window update is a single pass.
// Throughput: one request per cycle unless the result side holds off.
// Reset: rst_n clears window, fill, position, stream length, both valid flags.
// ---------------------------------------------------------------------------
`include "bitstream_field_reader_assert.svh"

module bitstream_field_reader #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [bfr_pkg::BYTE_W-1:0]          byte_in,
    input  logic [bfr_pkg::CNT_W-1:0]           bit_count,
    input  logic                                consume,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [bfr_pkg::FIELD_W-1:0]         field_bits,
    output logic [bfr_pkg::LEN_W-1:0]           consumed_bytes,
    output logic [bfr_pkg::LEN_W-1:0]           bytes_left,
    // stream length register
    input  logic                                cfg_wr_en,
    input  logic [bfr_pkg::LEN_W-1:0]           cfg_wr_data
);

    // Stage 1 holds the accepted request, stage 2 holds the finished result.
    // A request moves from stage 1 to stage 2 (and updates the window) when
    // stage 2 is empty or its result is being taken in the same cycle, so
    // the request side keeps flowing while results are taken; a result that
    // is held off stalls the request side once stage 1 is also full.

    logic                          in_valid_reg;
    bfr_pkg::req_t                 req_reg;
    logic                          out_valid_reg;
    bfr_pkg::rsp_t                 rsp_reg;
    logic [bfr_pkg::LEN_W-1:0]     stream_bytes_reg;

    bfr_pkg::rsp_t                 rsp_next;
    logic                          advance;
    logic                          in_take;

    // advance the held request whenever the result stage can take it
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    bfr_core #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .req          (req_reg),
        .stream_bytes (stream_bytes_reg),
        .rsp          (rsp_next)
    );

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset: qualified by in_valid_reg
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.opcode    <= bfr_pkg::op_t'(opcode);
            req_reg.byte_in   <= byte_in;
            req_reg.bit_count <= bit_count;
            req_reg.consume   <= consume;
        end
    end

    // result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // stream length; to be written only while no request is in flight (the user's duty, not enforced by the block)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_bytes_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            stream_bytes_reg <= cfg_wr_data;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = rsp_reg.status;
    assign field_bits     = rsp_reg.field_bits;
    assign consumed_bytes = rsp_reg.consumed_bytes;
    assign bytes_left     = rsp_reg.bytes_left;

    `BFR_ASSERT_ALWAYS(a_stall_only_when_full,
                       !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready));
    `BFR_ASSERT_NEXT(a_advance_loads_result, advance, out_valid_reg);
    `BFR_ASSERT_ALWAYS(a_result_from_request, $rose(out_valid_reg) |-> $past(in_valid_reg));

endmodule

FILE: rtl/bfr_core.sv
// ---------------------------------------------------------------------------
// Bitstream field reader core
// Bit window, fill level and stream position, with the update for a single
// request and the result it produces.
// ---------------------------------------------------------------------------
`include "bitstream_field_reader_assert.svh"

module bfr_core #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  bfr_pkg::req_t              req,
    input  logic [bfr_pkg::LEN_W-1:0]  stream_bytes,
    output bfr_pkg::rsp_t              rsp
);

    localparam int FILL_W = $clog2(WINDOW_BITS + 1);
    localparam logic [FILL_W-1:0] PUSH_LIMIT = FILL_W'(WINDOW_BITS - bfr_pkg::BYTE_W);
    localparam logic [bfr_pkg::CNT_W-1:0] MAX_CNT = bfr_pkg::CNT_W'(bfr_pkg::MAX_FIELD_BITS);
    localparam logic [bfr_pkg::CNT_W-1:0] FIELD_CNT = bfr_pkg::CNT_W'(bfr_pkg::FIELD_W);
    localparam logic [3:0] BYTE_CNT = 4'(bfr_pkg::BYTE_W);

    logic [WINDOW_BITS-1:0]        window_reg;
    logic [WINDOW_BITS-1:0]        window_next;
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic [bfr_pkg::POS_W-1:0]     consumed_reg;
    logic [bfr_pkg::POS_W-1:0]     consumed_next;

    logic [bfr_pkg::CNT_W-1:0]     cnt;
    logic [bfr_pkg::CNT_W-1:0]     adv;
    logic [bfr_pkg::FIELD_W-1:0]   top_bits;
    logic [3:0]                    align_gap;
    logic [bfr_pkg::POS_W:0]       round_up;
    logic [bfr_pkg::LEN_W-1:0]     cbytes;
    bfr_pkg::status_t              status;
    logic [bfr_pkg::FIELD_W-1:0]   field;

    assign cnt       = (req.bit_count > MAX_CNT) ? MAX_CNT : req.bit_count;
    assign top_bits  = window_reg[WINDOW_BITS-1 -: bfr_pkg::FIELD_W];
    assign align_gap = BYTE_CNT - {1'b0, consumed_reg[2:0]};

    always_comb
    begin
        status        = bfr_pkg::ST_OK;
        field         = '0;
        adv           = '0;
        window_next   = window_reg;
        fill_next     = fill_reg;
        consumed_next = consumed_reg;
        unique case (req.opcode)
            bfr_pkg::OP_PUSH:
            begin
                if (fill_reg > PUSH_LIMIT)
                begin
                    status = bfr_pkg::ST_DROPPED;
                end
                else
                begin
                    // drop the new byte in just below the buffered bits
                    window_next = window_reg
                                | (WINDOW_BITS'(req.byte_in) << (PUSH_LIMIT - fill_reg));
                    fill_next   = fill_reg + FILL_W'(bfr_pkg::BYTE_W);
                end
            end
            bfr_pkg::OP_GET:
            begin
                if (FILL_W'(cnt) > fill_reg)
                begin
                    status = bfr_pkg::ST_SHORT;
                end
                else if (cnt != '0)
                begin
                    field = top_bits >> (FIELD_CNT - cnt);
                    if (req.consume)
                    begin
                        adv = cnt;
                    end
                end
            end
            bfr_pkg::OP_ALIGN:
            begin
                if (consumed_reg[2:0] != 3'd0)
                begin
                    adv = (FILL_W'(align_gap) > fill_reg) ? bfr_pkg::CNT_W'(fill_reg)
                                                          : bfr_pkg::CNT_W'(align_gap);
                end
            end
            bfr_pkg::OP_RESTART:
            begin
                window_next   = '0;
                fill_next     = '0;
                consumed_next = '0;
            end
            default:
            begin
                status = bfr_pkg::ST_OK;
            end
        endcase
        // advance past consumed bits
        if (adv != '0)
        begin
            window_next   = window_reg << adv;
            fill_next     = fill_reg - FILL_W'(adv);
            consumed_next = consumed_reg + bfr_pkg::POS_W'(adv);
        end
    end

    always_comb
    begin
        round_up           = {1'b0, consumed_next} + (bfr_pkg::POS_W + 1)'(7);
        cbytes             = round_up[bfr_pkg::LEN_W+2:3];
        rsp.status         = status;
        rsp.field_bits     = field;
        rsp.consumed_bytes = cbytes;
        rsp.bytes_left     = (stream_bytes > cbytes) ? (stream_bytes - cbytes) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            fill_reg     <= '0;
            consumed_reg <= '0;
        end
        else if (step)
        begin
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            consumed_reg <= consumed_next;
        end
    end

    `BFR_ASSERT_ALWAYS(a_window_clean, (window_reg << fill_reg) == '0);
    `BFR_ASSERT_NEXT(a_restart_clears, step && req.opcode == bfr_pkg::OP_RESTART,
                     fill_reg == '0 && consumed_reg == '0 && window_reg == '0);
    `BFR_ASSERT_NEXT(a_short_holds, step && rsp.status == bfr_pkg::ST_SHORT,
                     $stable(fill_reg) && $stable(consumed_reg) && $stable(window_reg));

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Bitstream field reader testbench
// Sends push, get, align and restart requests through the request channel
// and checks every result against a bit-level shadow of the reader window.
// Both channels idle at random; the result side holds off at times so the
// reader fills up and stalls. The stream length is rewritten between phases.
// ---------------------------------------------------------------------------
module tb;

    localparam int WIN_BITS         = 64;
    localparam int RANDOM_PER_PHASE = 286;
    localparam int HOLD_CYCLES      = 300;
    localparam int HOLD_SPACING     = 700;

    // Clock, reset and the ports of the reader
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [1:0]                   opcode;
    logic [bfr_pkg::BYTE_W-1:0]   byte_in;
    logic [bfr_pkg::CNT_W-1:0]    bit_count;
    logic                         consume;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   status;
    logic [bfr_pkg::FIELD_W-1:0]  field_bits;
    logic [bfr_pkg::LEN_W-1:0]    consumed_bytes;
    logic [bfr_pkg::LEN_W-1:0]    bytes_left;
    logic                         cfg_wr_en = 1'b0;
    logic [bfr_pkg::LEN_W-1:0]    cfg_wr_data = '0;

    // Request on offer; its fields drive the payload ports
    bfr_pkg::req_t                offered = '0;

    // Requests waiting to be sent and results owed by the reader
    bfr_pkg::req_t                requests_queued[$];
    bfr_pkg::rsp_t                results_due[$];

    // Shadow copy of the reader: window, fill level, bit position, length
    logic [WIN_BITS-1:0]          shadow_window = '0;
    int                           shadow_fill = 0;
    logic [bfr_pkg::POS_W-1:0]    shadow_pos = '0;
    logic [bfr_pkg::LEN_W-1:0]    shadow_len = '0;

    // Rough fill level tracked while planning requests, to steer the mix
    int                           plan_fill = 0;

    // Idle controls and counters
    logic                         source_idle = 1'b1;
    logic                         sink_idle = 1'b1;
    int                           source_wait = 0;
    int                           sink_wait = 0;
    int                           hold_left = 0;
    int                           hold_mark = 500;
    int                           requests_taken = 0;
    int                           mismatch_count = 0;
    bfr_pkg::rsp_t                due_rsp;
    bfr_pkg::rsp_t                head_rsp;

    assign opcode    = offered.opcode;
    assign byte_in   = offered.byte_in;
    assign bit_count = offered.bit_count;
    assign consume   = offered.consume;

    bitstream_field_reader #(
        .WINDOW_BITS (WIN_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .byte_in        (byte_in),
        .bit_count      (bit_count),
        .consume        (consume),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .field_bits     (field_bits),
        .consumed_bytes (consumed_bytes),
        .bytes_left     (bytes_left),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Apply one accepted request to the shadow reader and return its result.
    // Fields are MSB-first: the oldest buffered bit sits at the window top.
    task automatic service_request(input bfr_pkg::req_t rq, output bfr_pkg::rsp_t rs);
        int                        take;
        logic [bfr_pkg::POS_W:0]   ceil_bits;
        rs = '0;
        rs.status = bfr_pkg::ST_OK;
        take = 0;
        case (rq.opcode)
            bfr_pkg::OP_PUSH:
            begin
                // Drop the byte when it does not fit the window
                if (shadow_fill > WIN_BITS - bfr_pkg::BYTE_W)
                    rs.status = bfr_pkg::ST_DROPPED;
                else
                begin
                    shadow_window = shadow_window
                        | ({rq.byte_in, {(WIN_BITS-bfr_pkg::BYTE_W){1'b0}}} >> shadow_fill);
                    shadow_fill += bfr_pkg::BYTE_W;
                end
            end
            bfr_pkg::OP_GET:
            begin
                // Clamp oversized counts to the widest field
                take = (rq.bit_count > bfr_pkg::MAX_FIELD_BITS) ? bfr_pkg::MAX_FIELD_BITS
                                                                : int'(rq.bit_count);
                if (take > shadow_fill)
                begin
                    rs.status = bfr_pkg::ST_SHORT;
                    take = 0;
                end
                else if (take != 0)
                begin
                    rs.field_bits = bfr_pkg::FIELD_W'(shadow_window >> (WIN_BITS - take));
                    if (!rq.consume)
                        take = 0;
                end
            end
            bfr_pkg::OP_ALIGN:
            begin
                // Skip to the next byte boundary of the stream
                if (shadow_pos[2:0] != 3'd0)
                begin
                    take = bfr_pkg::BYTE_W - int'(shadow_pos[2:0]);
                    if (take > shadow_fill)
                        take = shadow_fill;
                end
            end
            bfr_pkg::OP_RESTART:
            begin
                shadow_window = '0;
                shadow_fill = 0;
                shadow_pos = '0;
            end
            default:
            begin
            end
        endcase
        shadow_window = shadow_window << take;
        shadow_fill -= take;
        shadow_pos = shadow_pos + bfr_pkg::POS_W'(take);
        // Round the bit position up to bytes, then keep 24 bits
        ceil_bits = {1'b0, shadow_pos} + (bfr_pkg::POS_W+1)'(7);
        rs.consumed_bytes = ceil_bits[bfr_pkg::LEN_W+2:3];
        rs.bytes_left = (shadow_len > rs.consumed_bytes) ? shadow_len - rs.consumed_bytes
                                                          : '0;
    endtask

    // Queue one request and advance the planning fill level
    task automatic enqueue_request(input bfr_pkg::op_t op,
                                   input logic [bfr_pkg::BYTE_W-1:0] value,
                                   input logic [bfr_pkg::CNT_W-1:0] count,
                                   input logic take_bits);
        bfr_pkg::req_t rq;
        int            n;
        rq.opcode = op;
        rq.byte_in = value;
        rq.bit_count = count;
        rq.consume = take_bits;
        requests_queued.push_back(rq);
        n = (count > bfr_pkg::MAX_FIELD_BITS) ? bfr_pkg::MAX_FIELD_BITS : int'(count);
        case (op)
            bfr_pkg::OP_PUSH:
                if (plan_fill <= WIN_BITS - bfr_pkg::BYTE_W) plan_fill += bfr_pkg::BYTE_W;
            bfr_pkg::OP_GET:     if (take_bits && n <= plan_fill) plan_fill -= n;
            bfr_pkg::OP_ALIGN:   plan_fill -= plan_fill % bfr_pkg::BYTE_W;
            bfr_pkg::OP_RESTART: plan_fill = 0;
            default:             plan_fill = plan_fill;
        endcase
    endtask

    // Mostly well-formed traffic: pushes while there is room, gets that fit
    // the buffered bits. Some noise: full-window pushes, short and odd gets, occasional aligns and restarts.
    task automatic plan_random_request();
        int                          pick;
        bfr_pkg::op_t                op;
        logic [bfr_pkg::CNT_W-1:0]   count;
        pick = $urandom_range(0, 99);
        count = bfr_pkg::CNT_W'($urandom_range(0, 63));
        if (pick < 2)
            op = bfr_pkg::OP_RESTART;
        else if (pick < 8)
            op = bfr_pkg::OP_ALIGN;
        else if (pick < 12 || (pick < 50 && plan_fill <= WIN_BITS - bfr_pkg::BYTE_W))
            op = bfr_pkg::OP_PUSH;
        else
        begin
            op = bfr_pkg::OP_GET;
            if (plan_fill != 0 && $urandom_range(0, 9) != 0)
                count = bfr_pkg::CNT_W'($urandom_range(1,
                            (plan_fill > bfr_pkg::MAX_FIELD_BITS) ? bfr_pkg::MAX_FIELD_BITS
                                                                  : plan_fill));
        end
        enqueue_request(op, bfr_pkg::BYTE_W'($urandom_range(0, 255)), count,
                        $urandom_range(0, 3) != 0);
    endtask

    // Wait until no request is pending or in flight, then let the pipe settle
    task automatic wait_until_quiet();
        while (requests_queued.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the stream length while the reader is idle
    task automatic configure_length(input logic [bfr_pkg::LEN_W-1:0] len);
        wait_until_quiet();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [bfr_pkg::LEN_W-1:0] len,
                                    input logic src_gaps, input logic snk_gaps);
        configure_length(len);
        source_idle <= src_gaps;
        sink_idle <= snk_gaps;
        repeat (RANDOM_PER_PHASE) plan_random_request();
    endtask

    // Driver: track the length register, record accepted requests in the
    // shadow, and offer the next request after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offered <= '0;
            source_wait <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                shadow_len = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                service_request(offered, due_rsp);
                results_due.push_back(due_rsp);
                requests_taken <= requests_taken + 1;
            end
            // Hold the payload until accepted; advance only when the slot frees
            if (!in_valid || in_ready)
            begin
                if (source_wait != 0)
                begin
                    source_wait <= source_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (requests_queued.size() != 0)
                begin
                    offered <= requests_queued.pop_front();
                    in_valid <= 1'b1;
                    source_wait <= source_idle ? gap_len() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side: once the accepted count passes a
    // mark, hold off for a fixed stretch so the reader backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_mark <= 500;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (requests_taken >= hold_mark)
        begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= hold_mark + HOLD_SPACING;
        end
    end

    // Monitor: compare each accepted result with the oldest one owed,
    // then decide whether to stall the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, status %0d field %h",
                             $time, status, field_bits);
                    mismatch_count++;
                end
                else
                begin
                    head_rsp = results_due.pop_front();
                    if (status !== head_rsp.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, head_rsp.status, status);
                        mismatch_count++;
                    end
                    if (field_bits !== head_rsp.field_bits)
                    begin
                        $display("%0t: field_bits expected %h, got %h",
                                 $time, head_rsp.field_bits, field_bits);
                        mismatch_count++;
                    end
                    if (consumed_bytes !== head_rsp.consumed_bytes)
                    begin
                        $display("%0t: consumed_bytes expected %0d, got %0d",
                                 $time, head_rsp.consumed_bytes, consumed_bytes);
                        mismatch_count++;
                    end
                    if (bytes_left !== head_rsp.bytes_left)
                    begin
                        $display("%0t: bytes_left expected %0d, got %0d",
                                 $time, head_rsp.bytes_left, bytes_left);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else if (sink_wait != 0)
            begin
                sink_wait <= sink_wait - 1;
                out_ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 3) == 0)
            begin
                sink_wait <= gap_len();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus: directed requests first, then random phases under
    // different stream lengths and idle patterns.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Short length so the remaining byte count saturates early
        configure_length(24'd5);

        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd1, 1'b1);      // nothing buffered yet
        enqueue_request(bfr_pkg::OP_ALIGN, 8'hFF, 6'd0, 1'b0);    // already on a boundary
        enqueue_request(bfr_pkg::OP_PUSH, 8'hFF, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_PUSH, 8'h00, 6'd63, 1'b1);
        enqueue_request(bfr_pkg::OP_PUSH, 8'hA5, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_PUSH, 8'h5A, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_PUSH, 8'h3C, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_PUSH, 8'hC3, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_PUSH, 8'h81, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_PUSH, 8'h7E, 6'd0, 1'b0);     // window now full
        enqueue_request(bfr_pkg::OP_PUSH, 8'h99, 6'd0, 1'b0);     // dropped
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd0, 1'b1);      // zero count
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd63, 1'b0);     // oversized peek
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd3, 1'b1);
        enqueue_request(bfr_pkg::OP_ALIGN, 8'h00, 6'd0, 1'b1);    // skip five bits
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd32, 1'b1);
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd33, 1'b1);     // clamped, too few bits
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd24, 1'b0);
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd24, 1'b1);     // drains the window
        enqueue_request(bfr_pkg::OP_PUSH, 8'h80, 6'd0, 1'b0);
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd1, 1'b1);
        enqueue_request(bfr_pkg::OP_ALIGN, 8'h00, 6'd0, 1'b0);    // skip seven bits
        enqueue_request(bfr_pkg::OP_GET, 8'h00, 6'd8, 1'b1);      // too few bits, window already empty
        enqueue_request(bfr_pkg::OP_RESTART, 8'hFF, 6'd63, 1'b1);

        run_random_phase(24'd0, 1'b1, 1'b1);
        run_random_phase(24'hFFFFFF, 1'b0, 1'b0);
        run_random_phase(24'd40, 1'b1, 1'b0);
        run_random_phase(24'd1, 1'b0, 1'b1);
        run_random_phase(bfr_pkg::LEN_W'($urandom), 1'b1, 1'b1);

        wait_until_quiet();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drop the run if it hangs
    initial
    begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bfr_pkg.sv
rtl/bfr_core.sv
rtl/bitstream_field_reader.sv
tb/sv/tb.sv
